// ----- src/tdpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg: shared definitions for the trial-division prime tester
// Widths, parameter defaults and the sequencer state type.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // Width of the candidate field on the input channel
  localparam int unsigned CandidateW = 31;

  // Default datapath width
  localparam int unsigned NumberBitsDef = 31;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_TRIAL,
    ST_DONE
  } tdpt_state_e;

endpackage

// ----- src/tdpt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_in_if: candidate channel
// Valid/ready channel carrying one candidate per transaction.
// ----------------------------------------------------------------------------
interface tdpt_in_if;
  logic                               valid;
  logic                               ready;
  logic [tdpt_pkg::CandidateW-1:0]    candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

// ----- src/tdpt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_out_if: verdict channel
// Valid/ready channel carrying one prime/not-prime flag per transaction.
// ----------------------------------------------------------------------------
interface tdpt_out_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

// ----- src/tdpt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_div: serial restoring divider
// One quotient bit per cycle; quotient and remainder valid when done_o
// pulses. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module tdpt_div #(
  parameter int unsigned NUMBER_BITS = tdpt_pkg::NumberBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUMBER_BITS-1:0] dividend_i,
  input  logic [NUMBER_BITS-1:0] divisor_i,
  output logic                   done_o,
  output logic [NUMBER_BITS-1:0] quotient_o,
  output logic [NUMBER_BITS-1:0] remainder_o
);

  localparam int unsigned W  = NUMBER_BITS;
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  dvs_q, dvs_d;

  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          fits;

  // One restoring step
  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  // Step / load control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[W-2:0], fits};
      rem_d = fits ? diff[W-1:0] : shifted[W-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ----- src/trial_division_prime_test_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit: primality test by trial division
//
// Usage: present a candidate on in_i; it is taken when valid and ready are
// both high. in_i.ready is high only while the unit is idle. The verdict
// appears on out_o and is held until the receiver takes it; only then does
// the unit return to idle and accept the next candidate. A stalled receiver
// therefore stalls the input side.
//
// Only the low NUMBER_BITS bits of the candidate are tested. Values below
// two go straight to the done state and report not prime. Otherwise the
// floor square root is found by Heron's iteration, then divisors 2..root
// are tried in turn, with an early exit on the first exact division.
// Every step uses one shared serial divider, which takes a new division
// only after the last one is done. Reset returns the unit to idle and
// drops any verdict in flight.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit #(
  parameter int unsigned NUMBER_BITS = tdpt_pkg::NumberBitsDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tdpt_in_if.sink    in_i,
  tdpt_out_if.source out_o
);

  localparam int unsigned W  = NUMBER_BITS;
  localparam int unsigned RW = (W + 1) / 2;
  localparam int unsigned CW = tdpt_pkg::CandidateW;

  tdpt_pkg::tdpt_state_e state_q, state_d;

  logic [W-1:0]  n_q, n_d;
  logic [W-1:0]  est_q, est_d;
  logic [RW-1:0] root_q, root_d;
  logic [RW-1:0] dvr_q, dvr_d;
  logic          prime_q, prime_d;

  logic          div_start;
  logic [W-1:0]  div_dividend;
  logic [W-1:0]  div_divisor;
  logic          div_done;
  logic [W-1:0]  div_quo;
  logic [W-1:0]  div_rem;

  logic [CW+W-1:0] cand_wide;
  logic [W-1:0]    cand;
  logic            cand_small;
  logic [W:0]      heron_sum;
  logic [W-1:0]    heron_next;
  logic            heron_falls;
  logic            root_small;
  logic            in_fire;
  logic            out_fire;

  // Fit the candidate to the datapath width
  assign cand_wide  = {{W{1'b0}}, in_i.candidate};
  assign cand       = cand_wide[W-1:0];
  assign cand_small = (cand[W-1:1] == '0);

  // Heron step from the finished quotient
  assign heron_sum   = {1'b0, est_q} + {1'b0, div_quo};
  assign heron_next  = heron_sum[W:1];
  assign heron_falls = heron_next < est_q;
  assign root_small  = (est_q[W-1:1] == '0);

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = cand_small ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_ROOT;
        end
      end
      tdpt_pkg::ST_ROOT: begin
        if (div_done && !heron_falls) begin
          state_d = root_small ? tdpt_pkg::ST_DONE : tdpt_pkg::ST_TRIAL;
        end
      end
      tdpt_pkg::ST_TRIAL: begin
        if (div_done && ((div_rem == '0) || (dvr_q == root_q))) begin
          state_d = tdpt_pkg::ST_DONE;
        end
      end
      tdpt_pkg::ST_DONE: begin
        if (out_fire) begin
          state_d = tdpt_pkg::ST_IDLE;
        end
      end
      default: state_d = tdpt_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates and divider requests
  always_comb begin
    n_d          = n_q;
    est_d        = est_q;
    root_d       = root_q;
    dvr_d        = dvr_q;
    prime_d      = prime_q;
    div_start    = 1'b0;
    div_dividend = n_q;
    div_divisor  = est_q;
    case (state_q)
      tdpt_pkg::ST_IDLE: begin
        if (in_fire) begin
          n_d     = cand;
          est_d   = cand >> 1;
          prime_d = 1'b0;
          if (!cand_small) begin
            div_start    = 1'b1;
            div_dividend = cand;
            div_divisor  = cand >> 1;
          end
        end
      end
      tdpt_pkg::ST_ROOT: begin
        if (div_done) begin
          if (heron_falls) begin
            est_d       = heron_next;
            div_start   = 1'b1;
            div_divisor = heron_next;
          end else begin
            root_d = est_q[RW-1:0];
            dvr_d  = RW'(2);
            if (root_small) begin
              prime_d = 1'b1;
            end else begin
              div_start   = 1'b1;
              div_divisor = W'(2);
            end
          end
        end
      end
      tdpt_pkg::ST_TRIAL: begin
        if (div_done) begin
          if (div_rem == '0) begin
            prime_d = 1'b0;
          end else if (dvr_q == root_q) begin
            prime_d = 1'b1;
          end else begin
            dvr_d       = dvr_q + RW'(1);
            div_start   = 1'b1;
            div_divisor = W'(dvr_q + RW'(1));
          end
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    est_q   <= est_d;
    root_q  <= root_d;
    dvr_q   <= dvr_d;
    prime_q <= prime_d;
  end

  // Shared divider
  tdpt_div #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Channel outputs
  assign in_i.ready     = (state_q == tdpt_pkg::ST_IDLE);
  assign out_o.valid    = (state_q == tdpt_pkg::ST_DONE);
  assign out_o.is_prime = prime_q;

endmodule

// ----- tb/trial_division_prime_test_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit_tb: self-checking bench for the prime tester
// Walks a table of corner candidates, then random ones, under several sender
// and receiver idling mixes; verdicts are checked against the table or model.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit_tb;

  localparam int unsigned CandW         = tdpt_pkg::CandidateW;
  localparam int unsigned NumBits       = tdpt_pkg::NumberBitsDef;
  localparam logic [63:0] DatapathMask  =
    (NumBits >= 64) ? '1 : ((64'd1 << NumBits) - 64'd1);
  // Random candidates are redrawn if they need more divider passes than this
  localparam int unsigned MaxDivisions  = 400;
  localparam int unsigned WatchdogLimit = 200000;
  localparam int unsigned TailCycles    = 100;
  localparam int unsigned RandPhases    = 4;
  localparam int unsigned ItemsPerPhase = 20;
  localparam int unsigned NumRows       = 22;

  // Model output: the verdict and the number of divider passes it costs
  typedef struct packed {
    logic        is_prime;
    int unsigned divisions;
  } verdict_t;

  // One pending verdict, tagged with its candidate for reporting
  typedef struct packed {
    logic [CandW-1:0] cand;
    logic             is_prime;
  } pending_verdict_t;

  // Directed row: candidate, whether the verdict is typed in, that verdict
  typedef struct packed {
    logic [CandW-1:0] cand;
    logic             known;
    logic             verdict;
  } stim_row_t;

  localparam stim_row_t DirectedRows [0:NumRows-1] = '{
    '{31'd0,          1'b1, 1'b0},  // below two
    '{31'd1,          1'b1, 1'b0},  // below two
    '{31'd2,          1'b1, 1'b1},  // root is one, no divisor tried
    '{31'd3,          1'b1, 1'b1},  // root is one, no divisor tried
    '{31'd4,          1'b1, 1'b0},
    '{31'd2147483646, 1'b1, 1'b0},  // largest even value
    '{31'd5,          1'b0, 1'b0},
    '{31'd9,          1'b0, 1'b0},  // square of a prime: root itself divides
    '{31'd25,         1'b0, 1'b0},
    '{31'd49,         1'b0, 1'b0},
    '{31'd97,         1'b0, 1'b0},
    '{31'd121,        1'b0, 1'b0},
    '{31'd961,        1'b0, 1'b0},
    '{31'd8191,       1'b0, 1'b0},
    '{31'd65521,      1'b0, 1'b0},
    '{31'd65535,      1'b0, 1'b0},
    '{31'd1000003,    1'b0, 1'b0},  // prime, ~1000 trials
    '{31'd1018081,    1'b0, 1'b0},  // 1009 squared, exits on the last trial
    '{31'd1073741824, 1'b0, 1'b0},  // only the top bit set
    '{31'd1431655765, 1'b0, 1'b0},  // alternating bits
    '{31'd715827882,  1'b0, 1'b0},  // alternating bits, other phase
    '{31'd2147483645, 1'b0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  tdpt_in_if  in_if ();
  tdpt_out_if out_if ();

  trial_division_prime_test_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  pending_verdict_t verdict_q[$];
  pending_verdict_t next_verdict;   // expectation for the candidate on the bus
  pending_verdict_t oldest;
  int unsigned      error_count;
  int unsigned      idle_cycles;
  int unsigned      tx_idle_pct;
  int unsigned      rx_stall_pct;

  // Primality by Heron root then trial division, at datapath width
  function automatic verdict_t predict_verdict(logic [CandW-1:0] cand);
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] nxt;
    logic [63:0] d;
    verdict_t    v;
    n           = 64'(cand) & DatapathMask;
    v.is_prime  = 1'b0;
    v.divisions = 0;
    if (n >= 64'd2) begin
      root        = n >> 1;
      nxt         = (root + n / root) >> 1;
      v.divisions = 1;
      while (nxt < root) begin
        root        = nxt;
        nxt         = (root + n / root) >> 1;
        v.divisions = v.divisions + 1;
      end
      v.is_prime = 1'b1;
      for (d = 64'd2; d <= root && v.is_prime; d = d + 64'd1) begin
        v.divisions = v.divisions + 1;
        if (n % d == 64'd0) v.is_prime = 1'b0;
      end
    end
    return v;
  endfunction

  // Mostly small values, some wide ones; slow candidates are redrawn
  function automatic logic [CandW-1:0] draw_candidate();
    logic [CandW-1:0] cand;
    int unsigned      pick;
    verdict_t         v;
    do begin
      pick = $urandom_range(0, 99);
      if (pick < 5)       cand = CandW'($urandom_range(0, 3));
      else if (pick < 55) cand = CandW'($urandom_range(0, 4095));
      else if (pick < 80) cand = CandW'($urandom_range(0, (1 << 20) - 1));
      else                cand = CandW'($urandom);
      v = predict_verdict(cand);
    end while (v.divisions > MaxDivisions);
    return cand;
  endfunction

  task automatic log_verdict_error(input string what, input logic [CandW-1:0] cand,
                                   input logic got, input logic want);
    $display("%0t ERROR: %s: candidate %0d got %b want %b", $time, what, cand, got, want);
    error_count = error_count + 1;
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_candidate(input logic [CandW-1:0] cand, input logic known,
                                input logic verdict);
    verdict_t v;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid     <= 1'b0;
      in_if.candidate <= CandW'($urandom);
      @(negedge clk_i);
    end
    v                     = predict_verdict(cand);
    next_verdict.cand     = cand;
    next_verdict.is_prime = known ? verdict : v.is_prime;
    in_if.valid          <= 1'b1;
    in_if.candidate      <= cand;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Monitor: record accepted candidates, check verdicts, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
        verdict_q.push_back(next_verdict);
      end
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (verdict_q.size() == 0) begin
          log_verdict_error("verdict with nothing pending", '0, out_if.is_prime, 1'bx);
        end else begin
          oldest = verdict_q.pop_front();
          if (out_if.is_prime !== oldest.is_prime) begin
            log_verdict_error("is_prime mismatch", oldest.cand, out_if.is_prime,
                              oldest.is_prime);
          end
        end
      end
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("%0t ERROR: no transaction for %0d cycles", $time, WatchdogLimit);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned tx_mix [0:RandPhases-1];
    int unsigned rx_mix [0:RandPhases-1];
    tx_mix = '{0, 75, 0, 13};
    rx_mix = '{0, 0, 75, 13};
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    next_verdict    = '0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.candidate = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners, back to back
    for (int r = 0; r < NumRows; r++) begin
      send_candidate(DirectedRows[r].cand, DirectedRows[r].known, DirectedRows[r].verdict);
    end

    // Random phases; drain fully before each new idling mix
    for (int p = 0; p < RandPhases; p++) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
      while (verdict_q.size() != 0) @(negedge clk_i);
      tx_idle_pct  = tx_mix[p];
      rx_stall_pct = rx_mix[p];
      for (int i = 0; i < ItemsPerPhase; i++) begin
        send_candidate(draw_candidate(), 1'b0, 1'b0);
      end
    end
    in_if.valid <= 1'b0;

    // Drain, then let any stray verdict show up
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
